@@ rtl/packet_buffer_start_time_core_defines.svh @@
// ----------------------------------------------------------------------------
// Packet buffer start time core: assertion macros
// Shared concurrent assertion helpers for the checker.
// ----------------------------------------------------------------------------
`ifndef PACKET_BUFFER_START_TIME_CORE_DEFINES_SVH
`define PACKET_BUFFER_START_TIME_CORE_DEFINES_SVH

// Property must hold at every clock edge outside reset.
`define PBST_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition must never be true outside reset.
`define PBST_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

@@ rtl/pbst_pkg.sv @@
// ----------------------------------------------------------------------------
// pbst_pkg
// Widths, constants and helpers for the packet buffer start time core.
// ----------------------------------------------------------------------------
package pbst_pkg;

  localparam int unsigned Depth = 64;
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned OccW  = $clog2(Depth + 1);
  localparam int unsigned CfgW  = 7;
  localparam int unsigned CmpW  = (CfgW > OccW) ? CfgW : OccW;
  localparam int unsigned TimeW = 32;
  localparam int unsigned ProcW = 16;

  localparam logic [CfgW-1:0] BufSizeRst = CfgW'(64);

  typedef logic [AddrW-1:0] addr_t;
  typedef logic [OccW-1:0]  occ_t;
  typedef logic [TimeW-1:0] time_t;
  typedef logic [ProcW-1:0] proc_t;
  typedef logic [CfgW-1:0]  cfg_t;

  typedef enum logic [1:0] {
    StIdle  = 2'b01,
    StCheck = 2'b10
  } state_e;

  // Circular increment of a FIFO pointer.
  function automatic addr_t next_idx(addr_t idx);
    addr_t res;
    if (idx == addr_t'(Depth - 1)) begin
      res = '0;
    end else begin
      res = idx + addr_t'(1);
    end
    return res;
  endfunction

endpackage

@@ rtl/pbst_if.sv @@
// ----------------------------------------------------------------------------
// pbst interfaces
// Valid/ready channels for request items and result items.
// ----------------------------------------------------------------------------
interface pbst_in_if;
  logic                valid;
  logic                ready;
  pbst_pkg::time_t     arrive_ts;
  pbst_pkg::proc_t     svc_time;

  modport source (output valid, output arrive_ts, output svc_time, input ready);
  modport sink   (input valid, input arrive_ts, input svc_time, output ready);
endinterface

interface pbst_out_if;
  logic                valid;
  logic                ready;
  logic                dropped;
  pbst_pkg::time_t     start_ts;

  modport source (output valid, output dropped, output start_ts, input ready);
  modport sink   (input valid, input dropped, input start_ts, output ready);
endinterface

@@ rtl/pbst_ram.sv @@
// ----------------------------------------------------------------------------
// pbst_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module pbst_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

@@ rtl/packet_buffer_start_time_core.sv @@
// Flow: an accepted item is registered, then the check state retires expired entries
//   one per cycle and registers its result once the output register is free.
// Input: a new item is accepted only in the idle state, after the previous item's result
//   has been registered; that result may still wait in the output register.
// Reset: asynchronous, active low; clears pointers, occupancy and handshake state and
//   sets buffer_size to 64. The finish time RAM is not cleared (no clearing pass).
// ----------------------------------------------------------------------------
// packet_buffer_start_time_core
// Single-server packet buffer with tail drop. Finish times live in a RAM used
// as a circular FIFO; each request retires expired entries from the head,
// then drops or pushes its own finish time at the tail.
// ----------------------------------------------------------------------------
module packet_buffer_start_time_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  pbst_in_if.sink             in_ch,
  pbst_out_if.source          out_ch,
  input  logic                cfg_we_i,
  input  pbst_pkg::cfg_t      cfg_wdata_i
);
  import pbst_pkg::*;

  // Control state
  state_e state_q, state_d;
  addr_t  head_q, head_d;
  addr_t  tail_q, tail_d;
  occ_t   occ_q, occ_d;
  cfg_t   bsize_q;

  // Request under work and newest finish time (avoids a tail-1 RAM read)
  time_t  arr_q;
  proc_t  proc_q;
  time_t  last_fin_q;

  // Output register
  logic   out_valid_q;
  logic   out_drop_q;
  time_t  out_start_q;

  // RAM port
  addr_t  raddr;
  time_t  rdata;
  logic   we;
  time_t  fin;

  logic   accept;
  logic   in_check;
  logic   pop;
  logic   done;
  logic   drop;
  logic   [CmpW-1:0] cap;
  time_t  start;
  logic   [TimeW:0] sum;

  assign accept   = in_ch.valid & in_ch.ready;
  assign in_check = (state_q == StCheck);

  // Capacity is buffer_size clamped to the RAM depth.
  always_comb begin
    if (CmpW'(bsize_q) > CmpW'(Depth)) begin
      cap = CmpW'(Depth);
    end else begin
      cap = CmpW'(bsize_q);
    end
  end

  // rdata holds the head entry while in the check state. A pop fetches the
  // next head, so one entry retires per cycle.
  assign pop  = in_check && (occ_q != '0) && (rdata <= arr_q);
  assign done = in_check && !pop && (!out_valid_q || out_ch.ready);
  assign drop = CmpW'(occ_q) >= cap;

  assign start = (occ_q == '0) ? arr_q : last_fin_q;
  assign sum   = {1'b0, start} + {{(TimeW + 1 - ProcW){1'b0}}, proc_q};
  // Saturate at the all-ones time.
  assign fin   = sum[TimeW] ? '1 : sum[TimeW-1:0];

  assign we    = done && !drop;
  assign raddr = pop ? next_idx(head_q) : head_q;

  pbst_ram #(
    .Width (TimeW),
    .Depth (Depth),
    .AddrW (AddrW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (tail_q),
    .wdata_i (fin),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_comb begin
    state_d = state_q;
    head_d  = head_q;
    tail_d  = tail_q;
    occ_d   = occ_q;
    case (state_q)
      StIdle: begin
        if (accept) begin
          state_d = StCheck;
        end
      end
      StCheck: begin
        if (pop) begin
          head_d = next_idx(head_q);
          occ_d  = occ_q - occ_t'(1);
        end else if (done) begin
          state_d = StIdle;
          if (!drop) begin
            tail_d = next_idx(tail_q);
            occ_d  = occ_q + occ_t'(1);
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      head_q      <= '0;
      tail_q      <= '0;
      occ_q       <= '0;
      bsize_q     <= BufSizeRst;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      occ_q   <= occ_d;
      if (cfg_we_i) begin
        bsize_q <= cfg_wdata_i;
      end
      if (done) begin
        out_valid_q <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      arr_q  <= in_ch.arrive_ts;
      proc_q <= in_ch.svc_time;
    end
    if (we) begin
      last_fin_q <= fin;
    end
    if (done) begin
      out_drop_q  <= drop;
      out_start_q <= drop ? '0 : start;
    end
  end

  // A new item may enter while the previous result waits in the output register.
  assign in_ch.ready     = (state_q == StIdle);
  assign out_ch.valid    = out_valid_q;
  assign out_ch.dropped  = out_drop_q;
  assign out_ch.start_ts = out_start_q;

endmodule

@@ rtl/pbst_checker.sv @@
// ----------------------------------------------------------------------------
// pbst_checker
// Port-level checks for the packet buffer start time core.
// ----------------------------------------------------------------------------
`include "packet_buffer_start_time_core_defines.svh"

module pbst_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_i,
  input logic                out_valid_i,
  input logic                out_ready_i,
  input logic                out_dropped_i,
  input pbst_pkg::time_t     out_start_ts_i
);
  import pbst_pkg::*;

  logic       in_acc;
  logic       out_acc;
  logic       out_stall;
  logic       drop_seen;
  logic [1:0] pend_q;

  assign in_acc    = in_valid_i & in_ready_i;
  assign out_acc   = out_valid_i & out_ready_i;
  assign out_stall = out_valid_i & ~out_ready_i;
  assign drop_seen = out_valid_i & out_dropped_i;

  // Items accepted but not yet delivered.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_q + 2'(in_acc) - 2'(out_acc);
    end
  end

  `PBST_ASSERT(a_out_hold, clk_i, rst_ni, out_stall |=> out_valid_i, "result lost while stalled")
  `PBST_ASSERT(a_drop_zero, clk_i, rst_ni, drop_seen |-> out_start_ts_i == '0, "start on drop")
  `PBST_NEVER(a_no_invent, clk_i, rst_ni, out_valid_i && pend_q == 2'd0, "result without an item")
  `PBST_ASSERT(a_one_at_a_time, clk_i, rst_ni, in_acc |=> !in_ready_i, "accept while busy")

endmodule

bind packet_buffer_start_time_core pbst_checker u_pbst_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_ch.valid),
  .in_ready_i     (in_ch.ready),
  .out_valid_i    (out_ch.valid),
  .out_ready_i    (out_ch.ready),
  .out_dropped_i  (out_ch.dropped),
  .out_start_ts_i (out_ch.start_ts)
);
